[sv/rlss_pkg.sv]
// Shared types, register codes and reset values for the radio link supervisor.
// No dependencies; every other file refers to it by scoped names.
package rlss_pkg;

  typedef enum logic [2:0] {
    LS_START        = 3'd0,
    LS_CONNECTING   = 3'd1,
    LS_CONNECTED    = 3'd2,
    LS_LOST         = 3'd3,
    LS_DISCONNECTED = 3'd4,
    LS_TEST         = 3'd5
  } link_state_t;

  typedef enum logic [2:0] {
    CMD_NONE     = 3'd0,
    CMD_START    = 3'd1,
    CMD_SET_TIME = 3'd2,
    CMD_TEST     = 3'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_START_EXCH   = 3'd0,
    REG_CONNECT_EXCH = 3'd1,
    REG_LOST_LIMIT   = 3'd2,
    REG_SYNC_EXCH    = 3'd3,
    REG_SYNC_SECOND  = 3'd4,
    REG_TIME_OFFSET  = 3'd5
  } reg_idx_t;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [7:0] SYNC_GUARD    = 8'd10;
  localparam logic [5:0] SECS_PER_MIN  = 6'd60;
  localparam logic [7:0] CNT_MAX       = 8'd255;

  localparam logic [7:0] RST_START_EXCH   = 8'd3;
  localparam logic [7:0] RST_CONNECT_EXCH = 8'd10;
  localparam logic [7:0] RST_LOST_LIMIT   = 8'd20;
  localparam logic [7:0] RST_SYNC_EXCH    = 8'd3;
  localparam logic [5:0] RST_SYNC_SECOND  = 6'd55;
  localparam logic [7:0] RST_TIME_OFFSET  = 8'd65;

  typedef struct packed {
    logic [7:0] start_exchanges;
    logic [7:0] connect_exchanges;
    logic [7:0] lost_limit;
    logic [7:0] sync_exchange;
    logic [5:0] sync_second;
    logic [7:0] time_offset;
  } cfg_t;

  typedef struct packed {
    logic        ack_received;
    logic [2:0]  command;
    logic [31:0] srv_time;
  } in_item_t;

  typedef struct packed {
    link_state_t link_state;
    logic        fast_alarm_armed;
    logic        time_set_valid;
    logic [31:0] new_time;
    logic [7:0]  exchange_count;
  } out_item_t;

  // Residue mod 15: 16 == 1 (mod 15), so nibbles add up to the same residue.
  function automatic logic [3:0] mod15(input logic [31:0] v);
    logic [6:0] s;
    logic [4:0] f;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(v[4*i +: 4]);
    end
    f = 5'(s[6:4]) + 5'(s[3:0]);
    if (f >= 5'd15) begin
      f = f - 5'd15;
    end
    return f[3:0];
  endfunction

endpackage

[sv/rlss_cfg_regs.sv]
// APB-style configuration register file for the radio link supervisor.
// Depends on rlss_pkg for the register codes, reset values and cfg_t.
module rlss_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rlss_pkg::ADDR_W-1:0] paddr,
  input  logic [rlss_pkg::DATA_W-1:0] pwdata,
  output logic [rlss_pkg::DATA_W-1:0] prdata,
  output logic                      pready,
  output rlss_pkg::cfg_t            cfg
);

  rlss_pkg::cfg_t   cfg_r;
  rlss_pkg::cfg_t   cfg_nxt;
  rlss_pkg::reg_idx_t idx;
  logic             wr_en;

  assign idx    = rlss_pkg::reg_idx_t'(paddr[rlss_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        rlss_pkg::REG_START_EXCH:   cfg_nxt.start_exchanges   = pwdata[7:0];
        rlss_pkg::REG_CONNECT_EXCH: cfg_nxt.connect_exchanges = pwdata[7:0];
        rlss_pkg::REG_LOST_LIMIT:   cfg_nxt.lost_limit        = pwdata[7:0];
        rlss_pkg::REG_SYNC_EXCH:    cfg_nxt.sync_exchange     = pwdata[7:0];
        rlss_pkg::REG_SYNC_SECOND:  cfg_nxt.sync_second       = pwdata[5:0];
        rlss_pkg::REG_TIME_OFFSET:  cfg_nxt.time_offset       = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rlss_pkg::REG_START_EXCH:   prdata = 32'(cfg_r.start_exchanges);
      rlss_pkg::REG_CONNECT_EXCH: prdata = 32'(cfg_r.connect_exchanges);
      rlss_pkg::REG_LOST_LIMIT:   prdata = 32'(cfg_r.lost_limit);
      rlss_pkg::REG_SYNC_EXCH:    prdata = 32'(cfg_r.sync_exchange);
      rlss_pkg::REG_SYNC_SECOND:  prdata = 32'(cfg_r.sync_second);
      rlss_pkg::REG_TIME_OFFSET:  prdata = 32'(cfg_r.time_offset);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_exchanges   <= rlss_pkg::RST_START_EXCH;
      cfg_r.connect_exchanges <= rlss_pkg::RST_CONNECT_EXCH;
      cfg_r.lost_limit        <= rlss_pkg::RST_LOST_LIMIT;
      cfg_r.sync_exchange     <= rlss_pkg::RST_SYNC_EXCH;
      cfg_r.sync_second       <= rlss_pkg::RST_SYNC_SECOND;
      cfg_r.time_offset       <= rlss_pkg::RST_TIME_OFFSET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[sv/rlss_link_fsm.sv]
// Link state machine, saturating exchange counter and alarm flag.
// Depends on rlss_pkg; state advances once per request taken from the input stage.
module rlss_link_fsm (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  rlss_pkg::in_item_t  item,
  input  rlss_pkg::cfg_t      cfg,
  output rlss_pkg::out_item_t result
);

  rlss_pkg::link_state_t state_r;
  rlss_pkg::link_state_t state_nxt;
  rlss_pkg::link_state_t lost_st;
  logic [7:0]            cnt_r;
  logic [7:0]            cnt_nxt;
  logic [7:0]            cnt_inc;
  logic [7:0]            lost_cnt;
  logic                  alarm_r;
  logic                  alarm_nxt;
  logic                  changed;
  logic                  sec_match;
  logic                  tset;

  assign cnt_inc = (cnt_r == rlss_pkg::CNT_MAX) ? cnt_r : cnt_r + 8'd1;

  // Server second-of-minute equals sync_second, via mod 4 and mod 15 residues.
  assign sec_match = (cfg.sync_second < rlss_pkg::SECS_PER_MIN) &&
                     (item.srv_time[1:0] == cfg.sync_second[1:0]) &&
                     (rlss_pkg::mod15(item.srv_time) ==
                      rlss_pkg::mod15(32'(cfg.sync_second)));

  // Next state
  always_comb begin
    state_nxt = state_r;
    lost_st   = state_r;
    lost_cnt  = cnt_inc;
    if (!item.ack_received) begin
      if (state_r == rlss_pkg::LS_START || state_r == rlss_pkg::LS_CONNECTING ||
          state_r == rlss_pkg::LS_CONNECTED) begin
        lost_st  = rlss_pkg::LS_LOST;
        lost_cnt = '0;
      end
      if (lost_st == rlss_pkg::LS_LOST && lost_cnt >= cfg.lost_limit) begin
        state_nxt = rlss_pkg::LS_DISCONNECTED;
      end else begin
        state_nxt = lost_st;
      end
    end else begin
      case (item.command)
        rlss_pkg::CMD_NONE: begin
          unique case (state_r)
            rlss_pkg::LS_START:
              if (cnt_inc == cfg.start_exchanges) state_nxt = rlss_pkg::LS_CONNECTING;
            rlss_pkg::LS_CONNECTING:
              if (cnt_inc == cfg.connect_exchanges) state_nxt = rlss_pkg::LS_CONNECTED;
            rlss_pkg::LS_LOST,
            rlss_pkg::LS_DISCONNECTED:
              state_nxt = rlss_pkg::LS_CONNECTING;
            default: ;
          endcase
        end
        rlss_pkg::CMD_START: state_nxt = rlss_pkg::LS_START;
        rlss_pkg::CMD_TEST:  state_nxt = rlss_pkg::LS_TEST;
        default: ;
      endcase
    end
  end

  // Outputs and side registers
  always_comb begin
    changed   = (state_nxt != state_r);
    cnt_nxt   = changed ? 8'd0 : cnt_inc;
    alarm_nxt = alarm_r;
    if (changed) begin
      alarm_nxt = !(state_nxt == rlss_pkg::LS_CONNECTED ||
                    state_nxt == rlss_pkg::LS_DISCONNECTED);
    end
    tset = 1'b0;
    if (item.ack_received) begin
      if (item.command == rlss_pkg::CMD_SET_TIME) begin
        tset = 1'b1;
      end else if (item.command == rlss_pkg::CMD_NONE &&
                   state_r == rlss_pkg::LS_CONNECTED &&
                   cnt_inc < rlss_pkg::SYNC_GUARD &&
                   cnt_inc == cfg.sync_exchange && !sec_match) begin
        tset = 1'b1;
      end
    end
    result.link_state       = state_nxt;
    result.fast_alarm_armed = alarm_nxt;
    result.time_set_valid   = tset;
    result.new_time         = tset ? item.srv_time + 32'(cfg.time_offset) : 32'd0;
    result.exchange_count   = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rlss_pkg::LS_START;
      cnt_r   <= '0;
      alarm_r <= 1'b0;
    end else if (adv) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      alarm_r <= alarm_nxt;
    end
  end

endmodule

[sv/radio_link_state_supervisor.sv]
// Radio link state supervisor: input register, link FSM, result register.
// Result registered from the input register via the combinational FSM update; one request
// per cycle sustained while out_ready stays high.
// Synchronous active-low reset: link in start state, counter 0, alarm disarmed,
// configuration registers at their defaults, both pipeline stages empty.
// Depends on rlss_pkg, rlss_cfg_regs and rlss_link_fsm.
module radio_link_state_supervisor (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rlss_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rlss_pkg::out_item_t           out_data,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [rlss_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [rlss_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [rlss_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  rlss_pkg::cfg_t      cfg;
  rlss_pkg::in_item_t  item_r;
  rlss_pkg::out_item_t result;
  rlss_pkg::out_item_t out_r;
  logic                item_valid_r;
  logic                out_valid_r;
  logic                adv;

  // Request moves from the input stage to the result register.
  assign adv       = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  rlss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  rlss_link_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (adv) begin
      out_r <= result;
    end
  end

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("result register not loaded after advance");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> item_valid_r)
    else $error("input stage empty after accept");

  a_no_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.time_set_valid) |-> (out_r.new_time == 32'd0))
    else $error("new_time nonzero without time set");

  a_alarm_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.link_state == rlss_pkg::LS_CONNECTED ||
                     out_r.link_state == rlss_pkg::LS_DISCONNECTED))
    |-> !out_r.fast_alarm_armed)
    else $error("alarm armed in connected or disconnected state");

endmodule

[bench/radio_link_state_supervisor_test.sv]
// Self-checking bench for radio_link_state_supervisor: random and directed requests,
// APB register settings, in-bench link state predictor and in-order result checker.
// Depends on rlss_pkg and the radio_link_state_supervisor RTL.
`timescale 1ns / 1ps

module radio_link_state_supervisor_test;

  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 1000;
  localparam int TAIL_CYCLES = 4;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  rlss_pkg::in_item_t            in_data;
  logic                          out_valid;
  logic                          out_ready;
  rlss_pkg::out_item_t           out_data;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [rlss_pkg::ADDR_W-1:0]   cfg_paddr;
  logic [rlss_pkg::DATA_W-1:0]   cfg_pwdata;
  logic [rlss_pkg::DATA_W-1:0]   cfg_prdata;
  logic                          cfg_pready;

  radio_link_state_supervisor dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted link status and register copy
  rlss_pkg::link_state_t link_now;
  logic [7:0]            count_now;
  logic                  alarm_now;
  rlss_pkg::cfg_t        link_cfg;

  rlss_pkg::out_item_t   pending_results[$];
  rlss_pkg::out_item_t   want_result;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;
  bit          send_idle_en = 1'b0;
  bit          recv_idle_en = 1'b0;
  bit          hold_off_req = 1'b0;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void enter_state(input rlss_pkg::link_state_t nxt);
    if (nxt != link_now) begin
      link_now  = nxt;
      alarm_now = !(nxt == rlss_pkg::LS_CONNECTED || nxt == rlss_pkg::LS_DISCONNECTED);
      count_now = '0;
    end
  endfunction

  function automatic rlss_pkg::out_item_t predict_link(input rlss_pkg::in_item_t req);
    rlss_pkg::out_item_t r;
    logic [7:0]          cnt;
    r = '0;
    if (count_now != rlss_pkg::CNT_MAX) count_now = count_now + 8'd1;
    cnt = count_now;
    if (!req.ack_received) begin
      if (link_now == rlss_pkg::LS_START || link_now == rlss_pkg::LS_CONNECTING ||
          link_now == rlss_pkg::LS_CONNECTED)
        enter_state(rlss_pkg::LS_LOST);
      if (link_now == rlss_pkg::LS_LOST && count_now >= link_cfg.lost_limit) begin
        count_now = '0;
        enter_state(rlss_pkg::LS_DISCONNECTED);
      end
    end else begin
      case (req.command)
        rlss_pkg::CMD_NONE: begin
          case (link_now)
            rlss_pkg::LS_START: begin
              if (cnt == link_cfg.start_exchanges) enter_state(rlss_pkg::LS_CONNECTING);
            end
            rlss_pkg::LS_CONNECTING: begin
              if (cnt == link_cfg.connect_exchanges) begin
                enter_state(rlss_pkg::LS_CONNECTED);
                count_now = '0;
              end
            end
            rlss_pkg::LS_CONNECTED: begin
              if (cnt < rlss_pkg::SYNC_GUARD && cnt == link_cfg.sync_exchange &&
                  (req.srv_time % 32'd60) != 32'(link_cfg.sync_second)) begin
                r.time_set_valid = 1'b1;
                r.new_time = req.srv_time + 32'(link_cfg.time_offset);
              end
            end
            rlss_pkg::LS_LOST, rlss_pkg::LS_DISCONNECTED: begin
              enter_state(rlss_pkg::LS_CONNECTING);
              count_now = '0;
            end
            default: ;
          endcase
        end
        rlss_pkg::CMD_START: enter_state(rlss_pkg::LS_START);
        rlss_pkg::CMD_SET_TIME: begin
          r.time_set_valid = 1'b1;
          r.new_time = req.srv_time + 32'(link_cfg.time_offset);
        end
        rlss_pkg::CMD_TEST: enter_state(rlss_pkg::LS_TEST);
        default: ;
      endcase
    end
    r.link_state = link_now;
    r.fast_alarm_armed = alarm_now;
    r.exchange_count = count_now;
    return r;
  endfunction

  function automatic rlss_pkg::in_item_t random_request(input bit fail_only);
    rlss_pkg::in_item_t req;
    int unsigned        pick;
    pick = $urandom_range(0, 99);
    req.ack_received = !fail_only && pick >= 10;
    req.command = (req.ack_received && pick < 78) ? rlss_pkg::CMD_NONE :
                  3'($urandom_range(0, 7));
    // often land on the suppressing second so both sides of the sync check get hit
    if ($urandom_range(0, 2) == 0 && link_cfg.sync_second < rlss_pkg::SECS_PER_MIN)
      req.srv_time = $urandom_range(0, 71582787) * 60 + 32'(link_cfg.sync_second);
    else
      req.srv_time = $urandom;
    return req;
  endfunction

  task automatic send_request(input rlss_pkg::in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_link(req));
    if (send_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write, then read back; upper data bits carry junk that the block must drop
  task automatic write_register(input rlss_pkg::reg_idx_t idx, input logic [31:0] value);
    logic [31:0] stored;
    stored = (idx == rlss_pkg::REG_SYNC_SECOND) ? (value & 32'h3F) : (value & 32'hFF);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      rlss_pkg::REG_START_EXCH:   link_cfg.start_exchanges   = stored[7:0];
      rlss_pkg::REG_CONNECT_EXCH: link_cfg.connect_exchanges = stored[7:0];
      rlss_pkg::REG_LOST_LIMIT:   link_cfg.lost_limit        = stored[7:0];
      rlss_pkg::REG_SYNC_EXCH:    link_cfg.sync_exchange     = stored[7:0];
      rlss_pkg::REG_SYNC_SECOND:  link_cfg.sync_second       = stored[5:0];
      rlss_pkg::REG_TIME_OFFSET:  link_cfg.time_offset       = stored[7:0];
      default: ;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== stored)
      report_mismatch($sformatf("register %s reads 0x%0h want 0x%0h",
                                idx.name(), cfg_prdata, stored));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_link_config(input logic [7:0] start_n, input logic [7:0] connect_n,
                                 input logic [7:0] lost_n, input logic [7:0] sync_n,
                                 input logic [5:0] sync_sec, input logic [7:0] offset);
    wait_idle();
    write_register(rlss_pkg::REG_START_EXCH,
                   ($urandom & 32'hFFFF_FF00) | 32'(start_n));
    write_register(rlss_pkg::REG_CONNECT_EXCH,
                   ($urandom & 32'hFFFF_FF00) | 32'(connect_n));
    write_register(rlss_pkg::REG_LOST_LIMIT,
                   ($urandom & 32'hFFFF_FF00) | 32'(lost_n));
    write_register(rlss_pkg::REG_SYNC_EXCH,
                   ($urandom & 32'hFFFF_FF00) | 32'(sync_n));
    write_register(rlss_pkg::REG_SYNC_SECOND,
                   ($urandom & 32'hFFFF_FFC0) | 32'(sync_sec));
    write_register(rlss_pkg::REG_TIME_OFFSET,
                   ($urandom & 32'hFFFF_FF00) | 32'(offset));
  endtask

  // mostly acks with random content, with runs of failures so lost limits get reached
  task automatic run_random_phase(input int n);
    int sent;
    int burst;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 9) == 0) begin
        burst = $urandom_range(2, 10);
        repeat (burst) send_request(random_request(1'b1));
        sent += burst;
      end else begin
        send_request(random_request(1'b0));
        sent++;
      end
    end
  endtask

  task automatic test_default_settings();
    run_random_phase(20);
  endtask

  task automatic test_directed_cases();
    set_link_config(8'd2, 8'd3, 8'd0, 8'd2, 6'd7, 8'd255);
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_TEST, 32'd0});
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_START, 32'hFFFF_FFFF});
    // same state: counter kept
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_START, 32'd0});
    // start -> connecting -> connected
    repeat (4) send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_NONE, 32'd0});
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_NONE, 32'd0});
    // sync suppressed by second
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_NONE, 32'd307});
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_START, 32'd0});
    repeat (5) send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_NONE, 32'd0});
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_NONE, 32'd0});
    // sync issued, time wraps
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_NONE, 32'hFFFF_FFFF});
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_SET_TIME, 32'd0});
    for (int c = 4; c < 8; c++) send_request(rlss_pkg::in_item_t'{1'b1, 3'(c), 32'hA5A5_5A5A});
    // lost and disconnected at once
    send_request(rlss_pkg::in_item_t'{1'b0, rlss_pkg::CMD_TEST, 32'hFFFF_FFFF});
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_NONE, 32'd0});
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_TEST, 32'd0});
    send_request(rlss_pkg::in_item_t'{1'b0, rlss_pkg::CMD_SET_TIME, 32'h8000_0000});
  endtask

  task automatic test_counter_saturation();
    rlss_pkg::in_item_t req;
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_TEST, 32'd0});
    // anything but an acked start keeps the test state, so the counter runs to the top
    repeat (258) begin
      req = random_request(1'b0);
      if (req.ack_received && req.command == rlss_pkg::CMD_START)
        req.command = rlss_pkg::CMD_NONE;
      send_request(req);
    end
    send_request(rlss_pkg::in_item_t'{1'b1, rlss_pkg::CMD_START, 32'd0});
  endtask

  task automatic test_extreme_settings();
    set_link_config(8'd0, 8'd0, 8'd0, 8'd0, 6'd0, 8'd0);
    run_random_phase(12);
    set_link_config(8'd255, 8'd255, 8'd255, 8'd255, 6'd63, 8'd255);
    run_random_phase(12);
  endtask

  task automatic test_random_settings();
    // second of minute out of range: the correction can never be suppressed
    set_link_config(8'($urandom_range(1, 4)), 8'($urandom_range(1, 6)),
                    8'($urandom_range(0, 8)), 8'($urandom_range(1, 4)),
                    6'($urandom_range(60, 63)), 8'($urandom));
    run_random_phase(15);
    repeat (3) begin
      set_link_config(8'($urandom_range(1, 6)), 8'($urandom_range(1, 8)),
                      8'($urandom_range(0, 8)), 8'($urandom_range(0, 11)),
                      6'($urandom_range(0, 63)), 8'($urandom));
      run_random_phase(10);
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_en = 1'b0;
    hold_off_req = 1'b1;
    run_random_phase(20);
    send_idle_en = 1'b1;
  endtask

  task automatic test_streaming();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    set_link_config(8'd3, 8'd4, 8'd2, 8'd3, 6'd30, 8'd200);
    run_random_phase(20);
  endtask

  // result receiver: random stalls plus one long hold-off on request
  initial begin
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_ready <= 1'b1;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        want_result = pending_results.pop_front();
        check_field("link_state", 32'(out_data.link_state), 32'(want_result.link_state));
        check_field("fast_alarm_armed", 32'(out_data.fast_alarm_armed),
                    32'(want_result.fast_alarm_armed));
        check_field("time_set_valid", 32'(out_data.time_set_valid),
                    32'(want_result.time_set_valid));
        check_field("new_time", out_data.new_time, want_result.new_time);
        check_field("exchange_count", 32'(out_data.exchange_count),
                    32'(want_result.exchange_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("radio_link_state_supervisor regression: fail");
      $finish;
    end
  end

  initial begin
    link_now  = rlss_pkg::LS_START;
    count_now = '0;
    alarm_now = 1'b0;
    link_cfg  = '{rlss_pkg::RST_START_EXCH, rlss_pkg::RST_CONNECT_EXCH,
                  rlss_pkg::RST_LOST_LIMIT, rlss_pkg::RST_SYNC_EXCH,
                  rlss_pkg::RST_SYNC_SECOND, rlss_pkg::RST_TIME_OFFSET};
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;

    test_default_settings();
    test_directed_cases();
    test_counter_saturation();
    test_extreme_settings();
    test_random_settings();
    test_output_backpressure();
    test_streaming();

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("radio_link_state_supervisor regression: pass");
    else
      $display("radio_link_state_supervisor regression: fail");
    $finish;
  end

endmodule
